// ===== rtl/core/irct_pkg.sv =====
// Shared types, constants and character codes for the message tokenizer.
package irct_pkg;

  localparam int MAX_TOKEN  = 512;
  localparam int MAX_PARAMS = 16;

  localparam int TOK_LEN_W = 10;
  localparam int PIDX_W    = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] DEST_NONE    = 2'd0;
  localparam logic [1:0] DEST_SOURCE  = 2'd1;
  localparam logic [1:0] DEST_COMMAND = 2'd2;
  localparam logic [1:0] DEST_PARAM   = 2'd3;

  typedef enum logic [3:0] {
    PH_SKIP    = 4'b0001,
    PH_SOURCE  = 4'b0010,
    PH_COMMAND = 4'b0100,
    PH_ARGS    = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic                  trailing;
    logic [PIDX_W-1:0]     param_counter;
    logic [TOK_LEN_W-1:0]  token_length;
  } tok_state_t;

  typedef struct packed {
    logic [1:0]        dest;
    logic              byte_valid;
    logic [7:0]        out_byte;
    logic [PIDX_W-1:0] param_index;
    logic              param_done;
    logic              overflow;
    logic              line_done;
  } tok_result_t;

  localparam tok_state_t STATE_RESET = '{
    phase:         PH_SKIP,
    trailing:      1'b0,
    param_counter: '0,
    token_length:  '0
  };

endpackage

// ===== rtl/core/irct_step.sv =====
// Per-character next-state and result logic of the tokenizer.
module irct_step
  import irct_pkg::*;
(
  input  tok_state_t  state,
  input  logic [7:0]  ch,
  input  logic        last,
  output tok_state_t  state_next,
  output tok_result_t result
);

  logic       blank;
  logic       is_sep;
  logic       append;
  tok_state_t st;
  logic [1:0] phase_dest;

  assign blank  = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_sep = (ch == CH_SPACE) && ((state.phase != PH_ARGS) || !state.trailing);

  always_comb begin
    st     = state;
    append = 1'b0;
    result = '0;

    unique case (state.phase) inside
      PH_SKIP: begin
        if (blank) begin
          st = state;
        end else if (ch == CH_COLON) begin
          st.phase = PH_SOURCE;
        end else begin
          st.phase = PH_COMMAND;
          append   = 1'b1;
        end
      end
      PH_SOURCE, PH_COMMAND, PH_ARGS: begin
        if (is_sep) begin
          st.token_length = '0;
          if (state.phase == PH_SOURCE) begin
            st.phase = PH_COMMAND;
          end else if (state.phase == PH_COMMAND) begin
            st.phase         = PH_ARGS;
            st.param_counter = '0;
          end else begin
            result.param_done  = 1'b1;
            result.param_index = state.param_counter;
            // saturate at the top parameter index
            if (state.param_counter != PIDX_W'(MAX_PARAMS - 1)) begin
              st.param_counter = state.param_counter + 1'b1;
            end
          end
        end else if ((ch == CH_COLON) && !state.trailing) begin
          st.trailing = 1'b1;
        end else begin
          append = 1'b1;
        end
      end
      default: st = state;
    endcase

    unique case (st.phase)
      PH_SOURCE:  phase_dest = DEST_SOURCE;
      PH_COMMAND: phase_dest = DEST_COMMAND;
      PH_ARGS:    phase_dest = DEST_PARAM;
      default:    phase_dest = DEST_NONE;
    endcase

    if (append) begin
      result.dest = phase_dest;
      if (st.token_length < TOK_LEN_W'(MAX_TOKEN)) begin
        result.byte_valid = 1'b1;
        result.out_byte   = ch;
        st.token_length   = st.token_length + 1'b1;
      end else begin
        result.overflow = 1'b1;
      end
    end

    if ((st.phase == PH_ARGS) && !result.param_done) begin
      result.param_index = st.param_counter;
    end

    state_next = st;
    if (last) begin
      result.line_done = 1'b1;
      if (st.phase == PH_ARGS) begin
        result.param_done  = 1'b1;
        result.param_index = st.param_counter;
      end
      state_next = STATE_RESET;
    end
  end

endmodule

// ===== rtl/core/irct_skid.sv =====
// Output register with a one-entry skid stage for the result channel.
module irct_skid
  import irct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tok_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output tok_result_t out_data
);

  tok_result_t skid_data;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else if (full) begin
      if (out_free) begin
        out_valid <= 1'b1;
        full      <= 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        full <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (full) begin
      if (out_free) out_data <= skid_data;
    end else if (push) begin
      if (out_free) out_data <= push_data;
      else          skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/core/irc_message_tokenizer_core.sv =====
// Top level of the message line tokenizer: one character in, one routed result out.
// A result is registered in the output register, or the skid entry when stalled.
// Throughput: one character per cycle while in_stall is low (skid entry not full).
// A one-entry skid stage lets a transaction in while a finished result is still stalled.
// Reset (rst, synchronous): tokenizer back to skipping leading blanks, output side empty.
module irc_message_tokenizer_core
  import irct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // character channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            ch,
  input  logic                  last,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            dest,
  output logic                  byte_valid,
  output logic [7:0]            out_byte,
  output logic [PIDX_W-1:0]     param_index,
  output logic                  param_done,
  output logic                  overflow,
  output logic                  line_done
);

  tok_state_t  state;
  tok_state_t  state_next;
  tok_result_t step_res;
  tok_result_t out_res;
  logic        in_acc;
  logic        skid_full;

  // only the skid stage filling up holds the character channel back
  assign in_stall = skid_full;
  assign in_acc   = in_valid && !skid_full;

  // combinational step: phase, trailing flag, parameter counter, token length
  irct_step u_step (
    .state      (state),
    .ch         (ch),
    .last       (last),
    .state_next (state_next),
    .result     (step_res)
  );

  // tokenizer state moves only on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // result register plus skid entry
  irct_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc),
    .push_data (step_res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign dest        = out_res.dest;
  assign byte_valid  = out_res.byte_valid;
  assign out_byte    = out_res.out_byte;
  assign param_index = out_res.param_index;
  assign param_done  = out_res.param_done;
  assign overflow    = out_res.overflow;
  assign line_done   = out_res.line_done;

`ifndef SYNTHESIS
  // a kept byte always has a target and is never an overflow
  a_byte_routed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> ((dest != DEST_NONE) && !overflow))
    else $error("kept byte without target or with overflow");

  // a dropped or absent byte reads as zero
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (out_byte == 8'd0))
    else $error("out_byte non-zero without byte_valid");

  // skid entry only fills behind a held result
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid full with empty output register");

  // end of line returns the tokenizer to its reset state
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last) |=> (state == STATE_RESET))
    else $error("state not cleared after last character");
`endif

endmodule
